// File: sv/rcr_pkg.sv
// ----------------------------------------------------------------------------
// rcr_pkg: shared types and constants for route_concat_requant
// Register map, configuration bundle, queued beat layout, lane arithmetic.
// ----------------------------------------------------------------------------
package rcr_pkg;

	localparam int LANES        = 4;
	localparam int LANE_W       = 8;
	localparam int WORD_W       = LANES * LANE_W;
	localparam int ADDR_W       = 20;
	localparam int OFFS_W       = 9;          // first_words + second_words
	localparam int MULT_W       = 32;
	localparam int SHIFT_W      = 6;
	localparam int PROD_W       = LANE_W + MULT_W;
	localparam int SUM_W        = PROD_W + 1;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int M_DATA_W     = 56;         // word + address, padded to bytes
	localparam int QUEUE_DEPTH  = 4;
	localparam int MAX_PIXELS_DEF = 4096;

	// product magnitude never exceeds 2^38, so this shift or more rounds to 0
	localparam logic [SHIFT_W-1:0] ZERO_SHIFT = 6'd40;
	localparam logic [LANE_W-1:0]  SAT_POS    = 8'h7F;   // 127
	localparam logic [LANE_W-1:0]  SAT_NEG    = 8'h80;   // -128
	localparam logic [PROD_W-1:0]  MAG_POS    = PROD_W'(127);
	localparam logic [PROD_W-1:0]  MAG_NEG    = PROD_W'(128);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_COUNT   = 3'd0,
		REG_FIRST_WORDS   = 3'd1,
		REG_SECOND_WORDS  = 3'd2,
		REG_REQUANT_MASK  = 3'd3,
		REG_FIRST_MULT    = 3'd4,
		REG_SECOND_MULT   = 3'd5,
		REG_FIRST_SHIFT   = 3'd6,
		REG_SECOND_SHIFT  = 3'd7
	} rcr_reg_t;

	typedef struct packed {
		logic [12:0]         pixel_count;
		logic [7:0]          first_words;
		logic [7:0]          second_words;
		logic [1:0]          requant_enable_mask;
		logic [MULT_W-1:0]   first_multiplier;
		logic [MULT_W-1:0]   second_multiplier;
		logic [SHIFT_W-1:0]  first_shift;
		logic [SHIFT_W-1:0]  second_shift;
	} rcr_cfg_t;

	// classified beat as it waits between front and back
	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic               second;   // second-source phase
		logic               last;
		logic [OFFS_W-1:0]  offset;   // word offset inside the pixel
	} rcr_item_t;

endpackage

// File: sv/rcr_front.sv
// ----------------------------------------------------------------------------
// rcr_front: input side, position tracking
// Accepts beats, walks pixel/phase/word counters, tags each beat.
// ----------------------------------------------------------------------------
module rcr_front import rcr_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcr_cfg_t                      cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [WORD_W-1:0]             s_tdata,
	input  logic                          q_full,
	output logic                          push,
	output rcr_item_t                     item,
	output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] item_pixel
);

	localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CNT_W = $clog2(MAX_PIXELS + 1);

	logic [PIX_W-1:0]  pi_q;
	logic [7:0]        wi_q;
	logic              ss_q;

	logic [31:0]       pc_ext;
	logic [CNT_W-1:0]  cnt;
	logic [CNT_W-1:0]  p;
	logic [7:0]        w;
	logic              s;
	logic [OFFS_W-1:0] total;
	logic [OFFS_W-1:0] w_inc;
	logic              last;
	logic              accept;

	always_comb begin
		pc_ext = 32'(cfg.pixel_count);
		if (pc_ext == 32'd0) begin
			cnt = CNT_W'(1);
		end else if (pc_ext > 32'(MAX_PIXELS)) begin
			cnt = CNT_W'(MAX_PIXELS);
		end else begin
			cnt = CNT_W'(pc_ext);
		end
		total = OFFS_W'(cfg.first_words) + OFFS_W'(cfg.second_words);

		p = CNT_W'(pi_q);
		w = wi_q;
		s = ss_q;
		// stale position after a pixel count change
		if (p >= cnt) begin
			p = '0;
			w = '0;
			s = 1'b0;
		end
		if (!s && (w >= cfg.first_words)) begin
			s = 1'b1;
			w = '0;
		end
		if (s && (w >= cfg.second_words)) begin
			s = 1'b0;
			w = '0;
			p = p + CNT_W'(1);
			if (p >= cnt) begin
				p = '0;
			end
			if (cfg.first_words == 8'd0) begin
				s = 1'b1;
			end
		end

		w_inc = OFFS_W'(w) + OFFS_W'(1);
		if (s) begin
			last = (w_inc == OFFS_W'(cfg.second_words));
		end else begin
			last = (cfg.second_words == 8'd0) && (w_inc == OFFS_W'(cfg.first_words));
		end
		last = last && ((p + CNT_W'(1)) == cnt);

		item.word   = s_tdata;
		item.second = s;
		item.last   = last;
		item.offset = s ? (OFFS_W'(cfg.first_words) + OFFS_W'(w)) : OFFS_W'(w);
		item_pixel  = PIX_W'(p);
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	// nothing per pixel: beat is consumed and dropped
	assign push     = accept && (total != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pi_q <= '0;
			wi_q <= '0;
			ss_q <= 1'b0;
		end else if (push) begin
			if (last) begin
				pi_q <= '0;
				wi_q <= '0;
				ss_q <= 1'b0;
			end else begin
				pi_q <= PIX_W'(p);
				wi_q <= w + 8'd1;
				ss_q <= s;
			end
		end
	end

endmodule

// File: sv/rcr_queue.sv
// ----------------------------------------------------------------------------
// rcr_queue: small FIFO between front and back
// Register-based ring buffer, simultaneous push and pop.
// ----------------------------------------------------------------------------
module rcr_queue import rcr_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head_data,
	output logic         head_valid,
	output logic         full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
	endfunction

	assign head_data  = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: sv/rcr_back.sv
// ----------------------------------------------------------------------------
// rcr_back: requant and address pipeline
// Multiply, round, shift, saturate per lane; output register on the master side.
// ----------------------------------------------------------------------------
module rcr_back import rcr_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcr_cfg_t                      cfg,
	input  logic                          head_valid,
	input  rcr_item_t                     head_item,
	input  logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] head_pixel,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [M_DATA_W-1:0]           m_tdata,
	output logic                          m_tlast
);

	localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int AP_W  = (PIX_W + OFFS_W + 1 > ADDR_W) ? PIX_W + OFFS_W + 1 : ADDR_W;

	logic                       adv;

	// stage 1: products
	logic                       vld_s1;
	logic signed [PROD_W-1:0]   prod_s1 [LANES];
	logic [WORD_W-1:0]          word_s1;
	logic                       en_s1;
	logic [SHIFT_W-1:0]         sh_s1;
	logic [ADDR_W-1:0]          addr_s1;
	logic                       last_s1;

	// stage 2: rounded magnitudes
	logic                       vld_s2;
	logic [SUM_W-1:0]           sum_s2 [LANES];
	logic                       neg_s2 [LANES];
	logic                       zero_s2;
	logic [WORD_W-1:0]          word_s2;
	logic                       en_s2;
	logic [SHIFT_W-1:0]         sh_s2;
	logic [ADDR_W-1:0]          addr_s2;
	logic                       last_s2;

	// stage 3: output register
	logic                       vld_s3;
	logic [WORD_W-1:0]          word_s3;
	logic [ADDR_W-1:0]          addr_s3;
	logic                       last_s3;

	logic signed [MULT_W-1:0]   mult_sel;
	logic [SHIFT_W-1:0]         sh_sel;
	logic                       en_sel;
	logic [OFFS_W-1:0]          total;
	logic [AP_W-1:0]            addr_full;
	logic signed [PROD_W-1:0]   prod_c [LANES];
	logic [SUM_W-1:0]           rnd;
	logic [SUM_W-1:0]           sum_c  [LANES];
	logic                       neg_c  [LANES];
	logic [WORD_W-1:0]          word_c;

	assign adv = !vld_s3 || m_tready;
	assign pop = adv && head_valid;

	always_comb begin
		logic signed [LANE_W-1:0] lane;
		if (head_item.second) begin
			en_sel   = cfg.requant_enable_mask[1];
			mult_sel = $signed(cfg.second_multiplier);
			sh_sel   = cfg.second_shift;
		end else begin
			en_sel   = cfg.requant_enable_mask[0];
			mult_sel = $signed(cfg.first_multiplier);
			sh_sel   = cfg.first_shift;
		end
		total     = OFFS_W'(cfg.first_words) + OFFS_W'(cfg.second_words);
		addr_full = AP_W'(head_pixel) * AP_W'(total) + AP_W'(head_item.offset);
		for (int k = 0; k < LANES; k++) begin
			lane      = $signed(head_item.word[k*LANE_W +: LANE_W]);
			prod_c[k] = lane * mult_sel;
		end
	end

	// round half away from zero on the magnitude
	always_comb begin
		logic [PROD_W-1:0] mag;
		if ((sh_s1 == '0) || (sh_s1 >= ZERO_SHIFT)) begin
			rnd = '0;
		end else begin
			rnd = SUM_W'(1) << (sh_s1 - SHIFT_W'(1));
		end
		for (int k = 0; k < LANES; k++) begin
			neg_c[k] = prod_s1[k][PROD_W-1];
			mag      = neg_c[k] ? PROD_W'(-prod_s1[k]) : PROD_W'(prod_s1[k]);
			sum_c[k] = SUM_W'(mag) + rnd;
		end
	end

	always_comb begin
		logic [SUM_W-1:0] shifted;
		logic [LANE_W-1:0] res;
		for (int k = 0; k < LANES; k++) begin
			shifted = zero_s2 ? '0 : (sum_s2[k] >> sh_s2);
			if (neg_s2[k]) begin
				res = (shifted > SUM_W'(MAG_NEG)) ? SAT_NEG : LANE_W'(~shifted + SUM_W'(1));
			end else begin
				res = (shifted > SUM_W'(MAG_POS)) ? SAT_POS : shifted[LANE_W-1:0];
			end
			word_c[k*LANE_W +: LANE_W] = en_s2 ? res : word_s2[k*LANE_W +: LANE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= head_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < LANES; k++) begin
				prod_s1[k] <= prod_c[k];
				sum_s2[k]  <= sum_c[k];
				neg_s2[k]  <= neg_c[k];
			end
			word_s1 <= head_item.word;
			en_s1   <= en_sel;
			sh_s1   <= sh_sel;
			addr_s1 <= addr_full[ADDR_W-1:0];
			last_s1 <= head_item.last;

			zero_s2 <= (sh_s1 >= ZERO_SHIFT);
			word_s2 <= word_s1;
			en_s2   <= en_s1;
			sh_s2   <= sh_s1;
			addr_s2 <= addr_s1;
			last_s2 <= last_s1;

			word_s3 <= word_c;
			addr_s3 <= addr_s2;
			last_s3 <= last_s2;
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = {(M_DATA_W - WORD_W - ADDR_W)'(0), addr_s3, word_s3};
	assign m_tlast  = last_s3;

endmodule

// File: sv/route_concat_requant.sv
// ----------------------------------------------------------------------------
// route_concat_requant: int8 channel concat with per-source requant
// Tags each 4-lane word with its concat address and requantizes its lanes when enabled for its source.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*) carries source words in concat order: per pixel the
//   first-source words, then the second-source words. One beat = 4 int8 lanes.
//   Master stream (m_*) returns one beat per input beat: requantized lanes,
//   word address in the concatenated map, m_tlast on the image's final word.
//   Configuration goes through cfg_we/cfg_index/cfg_wdata, one register per
//   write; the user must change it only while the block is drained (the block does not enforce this).
//   Throughput: one beat per cycle while the output is not stalled, set by the four
//   lane multipliers that are pipelined with one beat in each stage.
//   Pipeline: an accepted beat passes the queue write, multiply, round, and
//   shift/saturate into the output register before m_tvalid rises.
//   With both words-per-pixel registers zero, beats are taken and dropped.
//   Stall: while m_tvalid is high and m_tready low the back pipeline holds;
//   the 4-entry queue keeps s_tready high until it fills.
//   Reset: counters restart at pixel 0, first source; registers take their
//   default values (pixel_count 1, first_words 1, rest 0).
// ----------------------------------------------------------------------------
module route_concat_requant import rcr_pkg::*; #(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// slave stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [WORD_W-1:0]      s_tdata,    // [31:0] in_word
	// master stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_DATA_W-1:0]    m_tdata,    // [31:0] out_word, [51:32] out_address
	output logic                   m_tlast,    // last_word
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int Q_W   = $bits(rcr_item_t) + PIX_W;

	rcr_cfg_t          cfg_q;

	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_valid;
	rcr_item_t         f_item;
	logic [PIX_W-1:0]  f_pixel;
	logic [Q_W-1:0]    q_head;
	rcr_item_t         b_item;
	logic [PIX_W-1:0]  b_pixel;

	// register file, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pixel_count: 13'd1, first_words: 8'd1, second_words: 8'd0,
				requant_enable_mask: 2'd0, first_multiplier: '0,
				second_multiplier: '0, first_shift: '0, second_shift: '0};
		end else if (cfg_we) begin
			unique case (rcr_reg_t'(cfg_index))
				REG_PIXEL_COUNT:  cfg_q.pixel_count         <= cfg_wdata[12:0];
				REG_FIRST_WORDS:  cfg_q.first_words         <= cfg_wdata[7:0];
				REG_SECOND_WORDS: cfg_q.second_words        <= cfg_wdata[7:0];
				REG_REQUANT_MASK: cfg_q.requant_enable_mask <= cfg_wdata[1:0];
				REG_FIRST_MULT:   cfg_q.first_multiplier    <= cfg_wdata[MULT_W-1:0];
				REG_SECOND_MULT:  cfg_q.second_multiplier   <= cfg_wdata[MULT_W-1:0];
				REG_FIRST_SHIFT:  cfg_q.first_shift         <= cfg_wdata[SHIFT_W-1:0];
				REG_SECOND_SHIFT: cfg_q.second_shift        <= cfg_wdata[SHIFT_W-1:0];
			endcase
		end
	end

	// front: position counters and beat tagging
	rcr_front #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_full     (q_full),
		.push       (q_push),
		.item       (f_item),
		.item_pixel (f_pixel)
	);

	// decouples input acceptance from output stalls
	rcr_queue #(
		.W     (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  ({f_item, f_pixel}),
		.pop        (q_pop),
		.head_data  (q_head),
		.head_valid (q_valid),
		.full       (q_full)
	);

	assign {b_item, b_pixel} = q_head;

	// back: lane requant and address generation
	rcr_back #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (q_valid),
		.head_item  (b_item),
		.head_pixel (b_pixel),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

`ifndef NO_ASSERTIONS
	// queue never written past capacity
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("queue push while full");

	// a tagged beat's offset lies inside the pixel
	a_offset_in_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (f_item.offset <
			(OFFS_W'(cfg_q.first_words) + OFFS_W'(cfg_q.second_words))))
		else $error("word offset outside pixel");

	// pop only drains occupied entries
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");
`endif

endmodule
